FILE: rtl/wskf_pkg.sv
// ----------------------------------------------------------------------------
// wskf_pkg
// shared constants, register codes and interface structs of the windowed
// scalar kalman filter
// ----------------------------------------------------------------------------
`default_nettype none

package wskf_pkg;

    localparam int WINDOW = 8;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ERR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 2'd2;

    localparam logic [DATA_W-1:0] MEAS_ERR_RST = 16'd256;
    localparam logic [DATA_W-1:0] INIT_ERR_RST = 16'd256;
    localparam logic [DATA_W-1:0] INIT_EST_RST = 16'd0;

    localparam logic [DATA_W-1:0] GAIN_MAX = 16'hFFFF;

    // request into the step unit
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] est;
        logic        [DATA_W-1:0] err;
        logic        [DATA_W-1:0] meas_err;
    } step_req_t;

    // response from the step unit
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] est;
        logic        [DATA_W-1:0] err;
    } step_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/wskf_window.sv
// ----------------------------------------------------------------------------
// wskf_window
// sample window: appends until full, then shifts the oldest sample out
// ----------------------------------------------------------------------------
`default_nettype none

module wskf_window
    import wskf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     clear,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic        [IDX_W-1:0]  rd_idx,
    output logic signed      [DATA_W-1:0] rd_data,
    output logic             [CNT_W-1:0]  fill
);

    logic signed [DATA_W-1:0] win_reg [WINDOW];
    logic        [CNT_W-1:0]  fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            fill_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            if (fill_reg < CNT_W'(WINDOW))
            begin
                win_reg[fill_reg[IDX_W-1:0]] <= sample;
                fill_reg <= fill_reg + 1'b1;
            end
            else
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW-1] <= sample;
            end
        end
    end

    assign rd_data = win_reg[rd_idx];
    assign fill    = fill_reg;

endmodule

`default_nettype wire

FILE: rtl/wskf_step.sv
// ----------------------------------------------------------------------------
// wskf_step
// one kalman step: restoring divider for the gain, then one shared
// multiplier for the estimate update and the error scaling
// ----------------------------------------------------------------------------
`default_nettype none

module wskf_step
    import wskf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire step_req_t req,
    output step_rsp_t      rsp
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_FIN  = 5'b10000
    } st_t;

    st_t state_reg, state_next;

    logic        [3:0]        cnt_reg;
    logic        [DATA_W:0]   rem_reg;
    logic        [DATA_W:0]   den_reg;
    logic        [DATA_W-1:0] gain_reg;
    logic        [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] est_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [35:0]       prod_reg;
    logic signed [DATA_W-1:0] est_out_reg;

    logic        [DATA_W+1:0] trial;
    logic                     fits;
    logic signed [17:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [35:0]       prod;
    logic signed [35:0]       rnd;
    logic signed [19:0]       est_delta;
    logic signed [21:0]       est_sum;
    logic signed [DATA_W-1:0] est_sat;
    logic        [DATA_W:0]   den_in;

    assign den_in = {1'b0, req.err} + {1'b0, req.meas_err};
    assign trial  = {rem_reg, 1'b0};
    assign fits   = trial >= {1'b0, den_reg};

    // operand select of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL1)
        begin
            mul_a = $signed({2'b00, gain_reg});
            mul_b = $signed({diff_reg[DATA_W], diff_reg});
        end
        else if (state_reg == ST_MUL2)
        begin
            mul_a = $signed({2'b00, err_reg});
            mul_b = $signed({1'b0, 17'h10000 - {1'b0, gain_reg}});
        end
    end

    assign prod = mul_a * mul_b;

    // round to nearest, ties upward
    assign rnd       = prod_reg + 36'sd32768;
    assign est_delta = rnd[35:16];
    assign est_sum   = 22'(est_reg) + 22'(est_delta);

    always_comb
    begin
        if (est_sum > 22'sd32767)
        begin
            est_sat = 16'sh7FFF;
        end
        else if (est_sum < -22'sd32768)
        begin
            est_sat = -16'sh8000;
        end
        else
        begin
            est_sat = est_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.meas_err == '0) ? ST_MUL1 : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 4'hF)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    err_reg  <= req.err;
                    est_reg  <= req.est;
                    diff_reg <= 17'(req.sample) - 17'(req.est);
                    den_reg  <= den_in;
                    rem_reg  <= {1'b0, req.err};
                    cnt_reg  <= '0;
                    // zero measurement error: gain saturates, or stays zero
                    gain_reg <= (req.err == '0) ? '0 : GAIN_MAX;
                end
            end
            ST_DIV:
            begin
                rem_reg  <= fits ? 17'(trial - {1'b0, den_reg}) : trial[DATA_W:0];
                gain_reg <= {gain_reg[DATA_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_MUL1:
            begin
                prod_reg <= prod;
            end
            ST_MUL2:
            begin
                est_out_reg <= est_sat;
                prod_reg    <= prod;
            end
            ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done = (state_reg == ST_FIN);
    assign rsp.est  = est_out_reg;
    assign rsp.err  = rnd[31:16];

endmodule

`default_nettype wire

FILE: rtl/windowed_scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// windowed_scalar_kalman_filter
// keeps a window of samples and runs a scalar kalman pass over it per push
// ----------------------------------------------------------------------------
// sequence: a push into a window that is not yet full goes straight to the
//   result register; a push into a full window runs WINDOW steps, each of
//   load, restoring gain division, two shared-multiplier steps and finish;
//   a zero measurement error skips the division
// throughput: one item at a time, s_tready is low while an item is at work
//   and while its result waits on m_tready
// reset: rst_n clears the window, the fill count and the sequencer at once and
//   loads the register reset values; no clearing pass is needed
`default_nettype none

module windowed_scalar_kalman_filter
    import wskf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,   // [15:0] sample
    input  wire logic                 s_tuser,   // [0] kind: 0 push, 1 clear
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata,   // [15:0] estimate
    output logic                      m_tuser,   // [0] ready_res
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } seq_t;

    seq_t state_reg, state_next;

    // configuration registers; estimate_error is always reloaded from
    // initial_estimate_error, so it shares that register; initial_estimate
    // only loads the running estimate
    logic        [DATA_W-1:0] meas_err_reg;
    logic        [DATA_W-1:0] init_err_reg;

    logic signed [DATA_W-1:0] run_est_reg;
    logic signed [DATA_W-1:0] work_est_reg;
    logic        [DATA_W-1:0] work_err_reg;
    logic signed [DATA_W-1:0] first_reg;
    logic        [IDX_W-1:0]  idx_reg;

    logic        [DATA_W-1:0] res_est_reg;
    logic                     res_rdy_reg;
    logic                     out_valid_reg;
    logic        [DATA_W-1:0] out_data_reg;
    logic                     out_user_reg;

    logic                     in_xfer;
    logic                     cfg_xfer;
    logic                     push;
    logic                     clear;
    logic                     full_after;
    logic                     out_free;
    logic signed [DATA_W-1:0] win_data;
    logic        [CNT_W-1:0]  fill;

    step_req_t step_req;
    step_rsp_t step_rsp;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign push      = in_xfer && !s_tuser;
    assign clear     = in_xfer && s_tuser;

    // window is full after this push when it held WINDOW-1 or more samples
    assign full_after = (fill >= CNT_W'(WINDOW - 1));

    // output slot free when empty or its transfer completes this cycle
    assign out_free = !out_valid_reg || m_tready;

    wskf_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .clear   (clear),
        .sample  (s_tdata),
        .rd_idx  (idx_reg),
        .rd_data (win_data),
        .fill    (fill)
    );

    assign step_req.start    = (state_reg == S_LOAD);
    assign step_req.sample   = win_data;
    assign step_req.est      = work_est_reg;
    assign step_req.err      = work_err_reg;
    assign step_req.meas_err = meas_err_reg;

    wskf_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (step_req),
        .rsp   (step_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    state_next = full_after ? S_LOAD : S_OUT;
                end
            end
            S_LOAD: state_next = S_WAIT;
            S_WAIT:
            begin
                if (step_rsp.done)
                begin
                    state_next = (idx_reg == IDX_W'(WINDOW - 1)) ? S_OUT : S_LOAD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            meas_err_reg  <= MEAS_ERR_RST;
            init_err_reg  <= INIT_ERR_RST;
            run_est_reg   <= INIT_EST_RST;
        end
        else
        begin
            state_reg <= state_next;

            // result register
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // register writes, taken only while idle
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    REG_MEAS_ERR: meas_err_reg <= cfg_data;
                    REG_INIT_ERR: init_err_reg <= cfg_data;
                    REG_INIT_EST:
                    begin
                        run_est_reg  <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (clear)
            begin
                run_est_reg <= '0;
            end
            else if (state_reg == S_WAIT && step_rsp.done
                     && idx_reg == IDX_W'(WINDOW - 1))
            begin
                // keep the estimate made after the oldest sample
                run_est_reg <= first_reg;
            end
        end
    end

    // pass datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            idx_reg      <= '0;
            work_est_reg <= run_est_reg;
            work_err_reg <= init_err_reg;
            res_est_reg  <= '0;
            res_rdy_reg  <= 1'b0;
        end
        else if (state_reg == S_WAIT && step_rsp.done)
        begin
            work_est_reg <= step_rsp.est;
            work_err_reg <= step_rsp.err;
            if (idx_reg == '0)
            begin
                first_reg <= step_rsp.est;
            end
            if (idx_reg == IDX_W'(WINDOW - 1))
            begin
                res_est_reg <= step_rsp.est;
                res_rdy_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end

        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= res_est_reg;
            out_user_reg <= res_rdy_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire
